[rtl/htfc_pkg.sv]
// shared types, constants and crc helper for the humidity/temperature frame checker
// no dependencies; imported by every module under rtl/

package htfc_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned TEMP_W = 15;
	localparam int unsigned HUM_W = 7;
	localparam int unsigned CODE_W = 2;
	localparam int unsigned COUNT_W = 8;

	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

	// temperature: -4500 + 17500*raw/65535 centidegrees
	localparam logic [14:0] TEMP_GAIN = 15'd17500;
	localparam logic [15:0] TEMP_OFFSET = 16'd4500;
	localparam logic signed [15:0] TEMP_MIN = -16'sd4000;
	localparam logic signed [15:0] TEMP_MAX = 16'sd12500;

	// humidity: -6 + 125*raw/65535 percent
	localparam logic [6:0] HUM_GAIN = 7'd125;
	localparam logic [22:0] HUM_ZERO_PROD = 23'd393210;
	localparam logic [7:0] HUM_OFFSET = 8'd6;
	localparam logic [7:0] HUM_MAX = 8'd100;

	localparam logic [16:0] FULL_SCALE = 17'd65535;

	typedef enum logic [CODE_W-1:0] {
		ERR_NONE     = 2'd0,
		ERR_BUS      = 2'd1,
		ERR_TEMP_CRC = 2'd2,
		ERR_HUM_CRC  = 2'd3
	} frame_err_t;

	typedef enum logic [CODE_W-1:0] {
		HEALTH_UNKNOWN = 2'd0,
		HEALTH_OK      = 2'd1,
		HEALTH_FAILED  = 2'd2
	} health_t;

	typedef struct packed {
		logic              bus_error;
		logic [BYTE_W-1:0] temp_msb;
		logic [BYTE_W-1:0] temp_lsb;
		logic [BYTE_W-1:0] temp_crc;
		logic [BYTE_W-1:0] hum_msb;
		logic [BYTE_W-1:0] hum_lsb;
		logic [BYTE_W-1:0] hum_crc;
	} in_item_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature_centi;
		logic [HUM_W-1:0]         humidity_pct;
		logic [CODE_W-1:0]        frame_error;
		logic [CODE_W-1:0]        sensor_health;
		logic [COUNT_W-1:0]       failure_count;
	} out_item_t;

	// per-frame verdict handed to the status registers
	typedef struct packed {
		logic                     update;
		frame_err_t               frame_error;
		logic signed [TEMP_W-1:0] temp_centi;
		logic [HUM_W-1:0]         hum_pct;
	} eval_t;

	function automatic logic [BYTE_W-1:0] crc8_byte(input logic [BYTE_W-1:0] crc_in,
			input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc_in ^ data;
		for (int i = 0; i < BYTE_W; i++) begin
			c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

[rtl/humidity_temp_frame_checker_core.sv]
// top level of the humidity/temperature frame checker: input register, result register
// depends on htfc_pkg, htfc_crc_check, htfc_convert, htfc_status
//
// usage:
//   in channel: one beat per completed sensor read (in_valid/in_stall, in_data struct).
//   out channel: one beat per input beat (out_valid/out_stall, out_data struct) carrying
//     the stored temperature and humidity, the frame's error code, health and failure count.
//   cfg channel: cfg_valid/cfg_ready with cfg_data = retry limit; cfg_ready is always high,
//     write only while no beat is in flight.
// an accepted input beat passes through the input register and then the result register on its way to out_data.
// throughput: one beat per cycle while out_stall is low; crc check, both conversions and the counter update sit
//   as combinational logic between the input register and the result register.
// stall: the result register holds while out_stall is high; the input register still
//   takes one more beat, then in_stall rises until the result is taken.
// reset: both valids drop, retry limit returns to 20, stored readings and failure count
//   clear and health goes to unknown.

module humidity_temp_frame_checker_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  htfc_pkg::in_item_t           in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output htfc_pkg::out_item_t          out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [htfc_pkg::BYTE_W-1:0]  cfg_data
);
	import htfc_pkg::*;

	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t item_s2;

	logic      advance;
	eval_t     eval;
	out_item_t result;

	assign advance = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid)
			item_s1 <= in_data;
		if (advance && valid_s1)
			item_s2 <= result;
	end

	htfc_crc_check u_crc (
		.item        (item_s1),
		.frame_error (eval.frame_error)
	);

	htfc_convert u_convert (
		.temp_raw   ({item_s1.temp_msb, item_s1.temp_lsb}),
		.hum_raw    ({item_s1.hum_msb, item_s1.hum_lsb}),
		.temp_centi (eval.temp_centi),
		.hum_pct    (eval.hum_pct)
	);

	assign eval.update = valid_s1 && advance;

	htfc_status u_status (
		.clk      (clk),
		.arst_n   (arst_n),
		.eval     (eval),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.result   (result)
	);

	assign out_valid = valid_s2;
	assign out_data = item_s2;

`ifndef SYNTHESIS
	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");
	a_item_moves_out: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> valid_s2)
		else $error("item lost between input and result register");
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");
`endif

endmodule

[rtl/htfc_crc_check.sv]
// crc-8 check of both words and error priority for one frame
// depends on htfc_pkg

module htfc_crc_check (
	input  htfc_pkg::in_item_t   item,
	output htfc_pkg::frame_err_t frame_error
);
	import htfc_pkg::*;

	logic [BYTE_W-1:0] temp_crc_calc;
	logic [BYTE_W-1:0] hum_crc_calc;

	assign temp_crc_calc = crc8_byte(crc8_byte(CRC_INIT, item.temp_msb), item.temp_lsb);
	assign hum_crc_calc = crc8_byte(crc8_byte(CRC_INIT, item.hum_msb), item.hum_lsb);

	// bus error hides both crc results
	always_comb begin
		if (item.bus_error)
			frame_error = ERR_BUS;
		else if (temp_crc_calc != item.temp_crc)
			frame_error = ERR_TEMP_CRC;
		else if (hum_crc_calc != item.hum_crc)
			frame_error = ERR_HUM_CRC;
		else
			frame_error = ERR_NONE;
	end

endmodule

[rtl/htfc_convert.sv]
// fixed-point conversion of raw words to centidegrees and percent
// depends on htfc_pkg; divide by 65535 done as shift plus one correction

module htfc_convert (
	input  logic [htfc_pkg::WORD_W-1:0]        temp_raw,
	input  logic [htfc_pkg::WORD_W-1:0]        hum_raw,
	output logic signed [htfc_pkg::TEMP_W-1:0] temp_centi,
	output logic [htfc_pkg::HUM_W-1:0]         hum_pct
);
	import htfc_pkg::*;

	logic [30:0]        t_prod;
	logic [16:0]        t_sum;
	logic               t_ge;
	logic [14:0]        t_quot;
	logic               t_rem_nz;
	logic               t_bump;
	logic signed [15:0] t_val;

	logic [22:0] h_prod;
	logic [16:0] h_sum;
	logic [7:0]  h_quot;
	logic [7:0]  h_val;

	// x/65535: with x = a*65536 + b, quotient is a plus one when a+b reaches 65535
	assign t_prod = 31'(TEMP_GAIN) * 31'(temp_raw);
	assign t_sum = 17'(t_prod[30:16]) + 17'(t_prod[15:0]);
	assign t_ge = (t_sum >= FULL_SCALE);
	assign t_quot = t_prod[30:16] + 15'(t_ge);
	assign t_rem_nz = t_ge ? (t_sum != FULL_SCALE) : (t_sum != 17'd0);
	// negative results truncate toward zero, so a nonzero remainder rounds up
	assign t_bump = (16'(t_quot) < TEMP_OFFSET) && t_rem_nz;
	assign t_val = $signed(16'(t_quot) - TEMP_OFFSET + 16'(t_bump));

	always_comb begin
		if (t_val < TEMP_MIN)
			temp_centi = TEMP_W'(TEMP_MIN);
		else if (t_val > TEMP_MAX)
			temp_centi = TEMP_W'(TEMP_MAX);
		else
			temp_centi = TEMP_W'(t_val);
	end

	assign h_prod = 23'(HUM_GAIN) * 23'(hum_raw);
	assign h_sum = 17'(h_prod[22:16]) + 17'(h_prod[15:0]);
	assign h_quot = 8'(h_prod[22:16]) + 8'(h_sum >= FULL_SCALE);
	assign h_val = h_quot - HUM_OFFSET;

	always_comb begin
		if (h_prod < HUM_ZERO_PROD)
			hum_pct = '0;
		else if (h_val > HUM_MAX)
			hum_pct = HUM_W'(HUM_MAX);
		else
			hum_pct = HUM_W'(h_val);
	end

endmodule

[rtl/htfc_status.sv]
// stored readings, failure counter, health code and retry limit register
// depends on htfc_pkg; produces the next result item from the frame verdict

module htfc_status (
	input  logic                         clk,
	input  logic                         arst_n,
	input  htfc_pkg::eval_t              eval,
	input  logic                         cfg_we,
	input  logic [htfc_pkg::BYTE_W-1:0]  cfg_data,
	output htfc_pkg::out_item_t          result
);
	import htfc_pkg::*;

	localparam logic [COUNT_W-1:0] LIMIT_RESET = 8'd20;

	logic [COUNT_W-1:0]       retry_limit_q;
	logic signed [TEMP_W-1:0] temp_q;
	logic [HUM_W-1:0]         hum_q;
	logic [COUNT_W-1:0]       fail_q;
	health_t                  health_q;

	logic signed [TEMP_W-1:0] temp_d;
	logic [HUM_W-1:0]         hum_d;
	logic [COUNT_W-1:0]       fail_d;
	health_t                  health_d;
	logic [COUNT_W:0]         fail_inc;

	always_comb begin
		temp_d = temp_q;
		hum_d = hum_q;
		health_d = health_q;
		fail_inc = (COUNT_W+1)'(fail_q) + 1'b1;
		if (eval.frame_error == ERR_NONE) begin
			temp_d = eval.temp_centi;
			hum_d = eval.hum_pct;
			fail_d = '0;
			health_d = HEALTH_OK;
		end else begin
			if (fail_inc > (COUNT_W+1)'(retry_limit_q)) begin
				fail_inc = (COUNT_W+1)'(retry_limit_q) + 1'b1;
				// a limit of 255 never flips health
				if (!fail_inc[COUNT_W])
					health_d = HEALTH_FAILED;
			end
			fail_d = fail_inc[COUNT_W] ? '1 : fail_inc[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= LIMIT_RESET;
			temp_q <= '0;
			hum_q <= '0;
			fail_q <= '0;
			health_q <= HEALTH_UNKNOWN;
		end else begin
			if (cfg_we)
				retry_limit_q <= cfg_data;
			if (eval.update) begin
				temp_q <= temp_d;
				hum_q <= hum_d;
				fail_q <= fail_d;
				health_q <= health_d;
			end
		end
	end

	assign result.temperature_centi = temp_d;
	assign result.humidity_pct = hum_d;
	assign result.frame_error = eval.frame_error;
	assign result.sensor_health = health_d;
	assign result.failure_count = fail_d;

`ifndef SYNTHESIS
	a_good_clears: assert property (@(posedge clk) disable iff (!arst_n)
		eval.update && eval.frame_error == ERR_NONE |=> fail_q == '0 && health_q == HEALTH_OK)
		else $error("good frame did not clear failure count");
	a_health_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		health_q != HEALTH_UNKNOWN |=> health_q != HEALTH_UNKNOWN)
		else $error("health returned to unknown");
	a_temp_range: assert property (@(posedge clk) disable iff (!arst_n)
		16'(temp_q) >= TEMP_MIN && 16'(temp_q) <= TEMP_MAX)
		else $error("stored temperature out of range");
`endif

endmodule

[tb/sv/htfc_frame_checker.sv]
// crc helper shared by the stimulus and the checker, and the checker module itself
// depends on htfc_pkg; watches the input, result and retry-limit channels of the core

package htfc_tb_pkg;

	import htfc_pkg::*;

	// bitwise crc-8 over the 16-bit word, msb first
	function automatic logic [7:0] sensor_crc8(input logic [15:0] word);
		logic [7:0] c;
		c = CRC_INIT;
		for (int i = 15; i >= 0; i--) begin
			c = (c[7] ^ word[i]) ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

module htfc_frame_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_stall,
	input  htfc_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_stall,
	input  htfc_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [7:0]          cfg_data,
	output int unsigned         mismatch_count,
	output int unsigned         outstanding
);

	timeunit 1ns;
	timeprecision 1ps;

	import htfc_pkg::*;
	import htfc_tb_pkg::*;

	localparam longint SCALE = 65535;
	localparam longint T_GAIN = 17500;
	localparam longint T_OFFSET = 4500;
	localparam longint T_LOW = -4000;
	localparam longint T_HIGH = 12500;
	localparam longint H_GAIN = 125;
	localparam longint H_OFFSET = 6;
	localparam longint H_HIGH = 100;
	localparam logic [7:0] LIMIT_AT_RESET = 8'd20;

	logic [7:0]                  retry_limit = LIMIT_AT_RESET;
	logic signed [TEMP_W-1:0]    stored_temp = '0;
	logic [HUM_W-1:0]            stored_hum = '0;
	logic [7:0]                  fail_cnt = '0;
	health_t                     health = HEALTH_UNKNOWN;
	out_item_t                   expected_readings[$];
	int unsigned                 fail_total = 0;
	int unsigned                 pending_count = 0;

	assign mismatch_count = fail_total;
	assign outstanding = pending_count;

	// advances the sensor state by one frame and returns the reading it reports
	function automatic out_item_t predict_reading(input in_item_t f);
		out_item_t r;
		frame_err_t code;
		logic [8:0] next_cnt;
		longint t_raw, h_raw, v;
		t_raw = {f.temp_msb, f.temp_lsb};
		h_raw = {f.hum_msb, f.hum_lsb};
		if (f.bus_error) begin
			code = ERR_BUS;
		end else if (sensor_crc8({f.temp_msb, f.temp_lsb}) != f.temp_crc) begin
			code = ERR_TEMP_CRC;
		end else if (sensor_crc8({f.hum_msb, f.hum_lsb}) != f.hum_crc) begin
			code = ERR_HUM_CRC;
		end else begin
			code = ERR_NONE;
		end
		if (code == ERR_NONE) begin
			v = (T_GAIN * t_raw - T_OFFSET * SCALE) / SCALE;
			if (v < T_LOW) v = T_LOW;
			if (v > T_HIGH) v = T_HIGH;
			stored_temp = v[TEMP_W-1:0];
			v = H_GAIN * h_raw - H_OFFSET * SCALE;
			if (v < 0) begin
				v = 0;
			end else begin
				v = v / SCALE;
				if (v > H_HIGH) v = H_HIGH;
			end
			stored_hum = v[HUM_W-1:0];
			fail_cnt = '0;
			health = HEALTH_OK;
		end else begin
			next_cnt = {1'b0, fail_cnt} + 9'd1;
			if (next_cnt > {1'b0, retry_limit}) begin
				next_cnt = {1'b0, retry_limit} + 9'd1;
				// a limit of 255 never trips the failed state
				if (next_cnt <= 9'd255) health = HEALTH_FAILED;
			end
			if (next_cnt > 9'd255) next_cnt = 9'd255;
			fail_cnt = next_cnt[7:0];
		end
		r.temperature_centi = stored_temp;
		r.humidity_pct = stored_hum;
		r.frame_error = code;
		r.sensor_health = health;
		r.failure_count = fail_cnt;
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit = LIMIT_AT_RESET;
			stored_temp = '0;
			stored_hum = '0;
			fail_cnt = '0;
			health = HEALTH_UNKNOWN;
			expected_readings.delete();
			pending_count = 0;
		end else begin
			if (cfg_valid && cfg_ready) retry_limit = cfg_data;
			if (in_valid && !in_stall) expected_readings.push_back(predict_reading(in_data));
			if (out_valid && !out_stall) begin
				if (expected_readings.size() == 0) begin
					$error("result beat with no reading expected");
					fail_total++;
				end else begin
					out_item_t want;
					want = expected_readings.pop_front();
					check_field("temperature_centi", longint'(want.temperature_centi),
						longint'($signed(out_data.temperature_centi)));
					check_field("humidity_pct", longint'(want.humidity_pct),
						longint'(out_data.humidity_pct));
					check_field("frame_error", longint'(want.frame_error),
						longint'(out_data.frame_error));
					check_field("sensor_health", longint'(want.sensor_health),
						longint'(out_data.sensor_health));
					check_field("failure_count", longint'(want.failure_count),
						longint'(out_data.failure_count));
				end
			end
			pending_count = expected_readings.size();
		end
	end

endmodule

[tb/sv/tb_humidity_temp_frame_checker_core.sv]
// stimulus and verdict for humidity_temp_frame_checker_core
// depends on htfc_pkg, htfc_tb_pkg and htfc_frame_checker (tb/sv/htfc_frame_checker.sv)

module tb_humidity_temp_frame_checker_core;

	timeunit 1ns;
	timeprecision 1ps;

	import htfc_pkg::*;
	import htfc_tb_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD = 300;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	in_item_t   in_data;
	logic       out_valid;
	logic       out_stall;
	out_item_t  out_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	int unsigned mismatch_count;
	int unsigned outstanding;
	int unsigned cycle_count = 0;
	bit          sender_quiet = 1'b1;
	bit          long_hold_req = 1'b0;
	bit          long_hold_done = 1'b0;

	humidity_temp_frame_checker_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	htfc_frame_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.mismatch_count(mismatch_count),
		.outstanding(outstanding)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// mostly short, now and then long
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic in_item_t make_frame(input logic bus, input logic [15:0] t_raw,
			input logic [15:0] h_raw, input logic bad_t, input logic bad_h);
		in_item_t f;
		f.bus_error = bus;
		{f.temp_msb, f.temp_lsb} = t_raw;
		{f.hum_msb, f.hum_lsb} = h_raw;
		f.temp_crc = sensor_crc8(t_raw) ^ (bad_t ? 8'($urandom_range(1, 255)) : 8'h00);
		f.hum_crc = sensor_crc8(h_raw) ^ (bad_h ? 8'($urandom_range(1, 255)) : 8'h00);
		return f;
	endfunction

	// random raw words, now and then one near the clamp and truncation edges of both conversions
	function automatic logic [15:0] random_raw();
		if ($urandom_range(0, 9) != 0) return 16'($urandom);
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'd1872;
			3: return 16'd1873;
			4: return 16'd16851;
			5: return 16'd16852;
			6: return 16'd63662;
			7: return 16'd63663;
			8: return 16'd3146;
			default: return 16'd55574;
		endcase
	endfunction

	function automatic in_item_t random_frame(input int fail_pct);
		in_item_t f;
		logic [63:0] noise;
		int kind;
		f = make_frame(1'b0, random_raw(), random_raw(), 1'b0, 1'b0);
		if ($urandom_range(0, 99) < fail_pct) begin
			kind = $urandom_range(0, 9);
			if (kind < 3) begin
				f = make_frame(1'b1, random_raw(), random_raw(), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end else if (kind < 6) begin
				f = make_frame(1'b0, random_raw(), random_raw(), 1'b1,
					1'($urandom_range(0, 1)));
			end else if (kind < 9) begin
				f = make_frame(1'b0, random_raw(), random_raw(), 1'b0, 1'b1);
			end else begin
				noise = {$urandom, $urandom};
				f = noise[$bits(in_item_t)-1:0];
			end
		end
		return f;
	endfunction

	task automatic send_frame(input in_item_t f);
		int gap;
		if ($urandom_range(0, 79) == 0) sender_quiet = !sender_quiet;
		gap = sender_quiet ? 0 : gap_len();
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data = f;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_limit(input logic [7:0] limit);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_data = limit;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic run_phase(input logic [7:0] limit, input int n_frames, input int fail_pct);
		write_limit(limit);
		send_frame(make_frame(1'b0, random_raw(), random_raw(), 1'b0, 1'b0));
		repeat (n_frames) send_frame(random_frame(fail_pct));
	endtask

	// result side: random stall bursts, calm stretches, one long hold-off on request
	initial begin : receiver
		int hold_left;
		int phase_left;
		bit calm;
		hold_left = 0;
		phase_left = 0;
		calm = 1'b1;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			// start the long hold only once the sender is offering beats again
			if (long_hold_req && !long_hold_done && in_valid) begin
				hold_left = LONG_HOLD;
				long_hold_done = 1'b1;
			end
			if (phase_left == 0) begin
				calm = ($urandom_range(0, 2) == 0);
				phase_left = $urandom_range(50, 300);
			end
			phase_left--;
			if (hold_left == 0 && !calm && $urandom_range(0, 3) == 0) hold_left = gap_len() + 1;
			out_stall = (hold_left != 0);
			if (hold_left != 0) hold_left--;
		end
	end

	initial begin : stimulus
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// no good read yet, then each error kind and the precedence between them
		send_frame(make_frame(1'b1, 16'h6666, 16'h6666, 1'b0, 1'b0));
		send_frame(make_frame(1'b1, 16'h1234, 16'hABCD, 1'b1, 1'b1));
		send_frame(make_frame(1'b0, 16'h4321, 16'h8000, 1'b1, 1'b0));
		send_frame(make_frame(1'b0, 16'h4321, 16'h8000, 1'b0, 1'b1));
		send_frame(make_frame(1'b0, 16'hFFFF, 16'h0000, 1'b1, 1'b1));
		// conversion extremes and clamp edges
		send_frame(make_frame(1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 16'd1872, 16'd3145, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 16'd1873, 16'd3146, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 16'd16851, 16'd55573, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 16'd16852, 16'd55574, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 16'd63662, 16'h8000, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 16'd63663, 16'h7FFF, 1'b0, 1'b0));
		send_frame('1);
		send_frame(make_frame(1'b0, 16'hAA55, 16'h55AA, 1'b0, 1'b0));
		repeat (5) send_frame(make_frame(1'b1, random_raw(), random_raw(), 1'b0, 1'b0));

		// limit dropped below the running count
		write_limit(8'd2);
		send_frame(make_frame(1'b0, 16'h0F0F, 16'hF0F0, 1'b1, 1'b0));
		send_frame(make_frame(1'b0, 16'h5A5A, 16'hA5A5, 1'b0, 1'b0));
		repeat (3) send_frame(make_frame(1'b0, random_raw(), random_raw(), 1'b0, 1'b1));
		// zero tolerance
		write_limit(8'd0);
		send_frame(make_frame(1'b0, 16'h3C3C, 16'hC3C3, 1'b0, 1'b0));
		send_frame(make_frame(1'b1, 16'h3C3C, 16'hC3C3, 1'b0, 1'b0));
		send_frame(make_frame(1'b0, 16'h3C3C, 16'hC3C3, 1'b0, 1'b0));

		// long failure runs: saturation at the top limit and at the never-fail limit
		run_phase(8'd254, 260, 100);
		run_phase(8'd255, 265, 100);

		for (int k = 0; k < 5; k++) begin
			if (k == 0) begin
				sender_quiet = 1'b1;
				long_hold_req = 1'b1;
			end
			run_phase(8'($urandom_range(0, 40)), 120, $urandom_range(15, 60));
		end
		write_limit(8'd20);

		wait_idle();
		repeat (10) @(negedge clk);
		if (mismatch_count == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

[files.f]
rtl/htfc_pkg.sv
rtl/htfc_crc_check.sv
rtl/htfc_convert.sv
rtl/htfc_status.sv
rtl/humidity_temp_frame_checker_core.sv
tb/sv/htfc_frame_checker.sv
tb/sv/tb_humidity_temp_frame_checker_core.sv
